### rtl/dzbr_pkg.sv
// ----------------------------------------------------------------------------
// dzbr_pkg
// Shared types and constants of the delta/zigzag/bit-width/run-length encoder.
// ----------------------------------------------------------------------------
package dzbr_pkg;

  // fixed field widths
  localparam int unsigned WordW    = 16;
  localparam int unsigned TokBitsW = 5;

  // default configuration
  localparam int unsigned DefChannels    = 4;
  localparam int unsigned DefRows        = 8;
  localparam int unsigned DefHeaderWidth = 5;
  localparam int unsigned DefRunWidth    = 8;

  // one output token
  typedef struct packed {
    logic [WordW-1:0]    value;
    logic [TokBitsW-1:0] nbits;
    logic                align;
    logic                last;
  } token_t;

  // sequencer commands to the history unit
  typedef struct packed {
    logic load;   // capture incoming sample
    logic calc;   // compute residual, update history, write store
    logic clear;  // drop set state: masks and position
  } hist_ctrl_t;

endpackage

### rtl/dzbr_store.sv
// ----------------------------------------------------------------------------
// dzbr_store
// Residual store of one set: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dzbr_store import dzbr_pkg::*; #(
  parameter int unsigned DEPTH = DefChannels * DefRows,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/dzbr_history.sv
// ----------------------------------------------------------------------------
// dzbr_history
// Per-channel sample history, second-order residual with zigzag coding,
// per-channel OR masks and the position within the current set.
// ----------------------------------------------------------------------------
module dzbr_history import dzbr_pkg::*; #(
  parameter int unsigned CHANNELS = DefChannels,
  parameter int unsigned ROWS     = DefRows,
  localparam int unsigned SetSize = CHANNELS * ROWS,
  localparam int unsigned AddrW   = $clog2(SetSize)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hist_ctrl_t                    ctrl_i,
  input  logic [WordW-1:0]              sample_i,
  output logic                          set_end_o,
  output logic [CHANNELS-1:0][WordW-1:0] masks_o,
  output logic                          wr_en_o,
  output logic [AddrW-1:0]              wr_addr_o,
  output logic [WordW-1:0]              wr_data_o
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChW-1:0]   LastCh  = ChW'(CHANNELS - 1);
  localparam logic [AddrW-1:0] LastPos = AddrW'(SetSize - 1);

  logic [WordW-1:0] older_q [CHANNELS];
  logic [WordW-1:0] newer_q [CHANNELS];
  logic [WordW-1:0] mask_q  [CHANNELS];
  logic [AddrW-1:0] pos_q;
  logic [ChW-1:0]   chan_q;
  logic [WordW-1:0] sample_q;
  logic [WordW-1:0] pred;
  logic [WordW-1:0] resid;
  logic [WordW-1:0] zz;

  // prediction 2*newer - older, residual, zigzag
  always_comb begin
    pred  = {newer_q[chan_q][WordW-2:0], 1'b0} - older_q[chan_q];
    resid = pred - sample_q;
    zz    = {resid[WordW-2:0], 1'b0} ^ {WordW{resid[WordW-1]}};
  end

  // sample capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sample_q <= sample_i;
    end
  end

  // history, masks and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        older_q[c] <= '0;
        newer_q[c] <= '0;
        mask_q[c]  <= '0;
      end
      pos_q  <= '0;
      chan_q <= '0;
    end else if (ctrl_i.clear) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mask_q[c] <= '0;
      end
      pos_q  <= '0;
      chan_q <= '0;
    end else if (ctrl_i.calc) begin
      older_q[chan_q] <= newer_q[chan_q];
      newer_q[chan_q] <= sample_q;
      mask_q[chan_q]  <= mask_q[chan_q] | zz;
      pos_q  <= (pos_q == LastPos) ? '0 : pos_q + AddrW'(1);
      chan_q <= (chan_q == LastCh) ? '0 : chan_q + ChW'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      masks_o[c] = mask_q[c];
    end
  end

  assign set_end_o = (pos_q == LastPos);
  assign wr_en_o   = ctrl_i.calc;
  assign wr_addr_o = pos_q;
  assign wr_data_o = zz;

endmodule

### rtl/dzbr_ctrl.sv
// ----------------------------------------------------------------------------
// dzbr_ctrl
// Sequencer: per-channel width unit stepped over the channels, zero-run
// counting and token generation into a single output register.
// ----------------------------------------------------------------------------
module dzbr_ctrl import dzbr_pkg::*; #(
  parameter int unsigned CHANNELS     = DefChannels,
  parameter int unsigned ROWS         = DefRows,
  parameter int unsigned HEADER_WIDTH = DefHeaderWidth,
  parameter int unsigned RUN_WIDTH    = DefRunWidth,
  localparam int unsigned SetSize = CHANNELS * ROWS,
  localparam int unsigned AddrW   = $clog2(SetSize)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input transaction
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_mode_i,
  // history unit
  output hist_ctrl_t                     hist_o,
  input  logic                           set_end_i,
  input  logic [CHANNELS-1:0][WordW-1:0] masks_i,
  // store read port
  output logic                           rd_en_o,
  output logic [AddrW-1:0]               rd_addr_o,
  input  logic [WordW-1:0]               rd_data_i,
  // output transaction
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output token_t                         out_tok_o
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ChW-1:0]       LastCh   = ChW'(CHANNELS - 1);
  localparam logic [AddrW-1:0]     LastPos  = AddrW'(SetSize - 1);
  localparam logic [RUN_WIDTH-1:0] RunLimit = '1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CALC    = 10'b00_0000_0010,
    S_WIDTH   = 10'b00_0000_0100,
    S_DECIDE  = 10'b00_0000_1000,
    S_RUN_HDR = 10'b00_0001_0000,
    S_RUN_CNT = 10'b00_0010_0000,
    S_HDR     = 10'b00_0100_0000,
    S_PAY_RD  = 10'b00_1000_0000,
    S_PAY_OUT = 10'b01_0000_0000,
    S_END_TOK = 10'b10_0000_0000
  } state_e;

  // what follows a run flush
  typedef enum logic [1:0] {
    K_END   = 2'd0,
    K_LIMIT = 2'd1,
    K_SET   = 2'd2
  } kind_e;

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [ChW-1:0]        idx_q, idx_d;
  logic [AddrW-1:0]      pay_q, pay_d;
  logic [ChW-1:0]        pch_q, pch_d;
  logic [TokBitsW-1:0]   widths_q [CHANNELS];
  logic [TokBitsW-1:0]   width_new;
  logic                  any_q, any_d;
  logic [RUN_WIDTH-1:0]  run_q, run_d;
  logic [RUN_WIDTH-1:0]  run_inc;
  token_t                tok;
  logic                  tok_en;
  logic                  emit;
  logic                  out_valid_q;
  token_t                out_q;
  logic                  in_acc;

  // width of the highest set bit
  function automatic logic [TokBitsW-1:0] bit_width(input logic [WordW-1:0] v);
    logic [TokBitsW-1:0] w;
    w = '0;
    for (int i = 0; i < WordW; i++) begin
      if (v[i]) begin
        w = TokBitsW'(i + 1);
      end
    end
    return w;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign width_new  = bit_width(masks_i[idx_q]);
  assign run_inc    = run_q + RUN_WIDTH'(1);
  assign emit       = tok_en && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    pay_d     = pay_q;
    pch_d     = pch_q;
    any_d     = any_q;
    run_d     = run_q;
    hist_o    = '0;
    rd_en_o   = 1'b0;
    rd_addr_o = pay_q;
    tok       = '0;
    tok_en    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode_i) begin
            hist_o.clear = 1'b1;
            kind_d       = K_END;
            idx_d        = '0;
            state_d      = (run_q != '0) ? S_RUN_HDR : S_END_TOK;
          end else begin
            hist_o.load = 1'b1;
            state_d     = S_CALC;
          end
        end
      end
      S_CALC: begin
        hist_o.calc = 1'b1;
        idx_d       = '0;
        any_d       = 1'b0;
        state_d     = set_end_i ? S_WIDTH : S_IDLE;
      end
      S_WIDTH: begin
        any_d = any_q || (width_new != '0);
        if (idx_q == LastCh) begin
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_q + ChW'(1);
        end
      end
      S_DECIDE: begin
        hist_o.clear = 1'b1;
        idx_d        = '0;
        if (!any_q) begin
          run_d = run_inc;
          if (run_inc == RunLimit) begin
            kind_d  = K_LIMIT;
            state_d = S_RUN_HDR;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          kind_d  = K_SET;
          state_d = (run_q != '0) ? S_RUN_HDR : S_HDR;
        end
      end
      S_RUN_HDR: begin
        tok_en      = 1'b1;
        tok.nbits   = TokBitsW'(HEADER_WIDTH);
        tok.align   = (idx_q == LastCh);
        if (emit) begin
          if (idx_q == LastCh) begin
            state_d = S_RUN_CNT;
          end else begin
            idx_d = idx_q + ChW'(1);
          end
        end
      end
      S_RUN_CNT: begin
        tok_en    = 1'b1;
        tok.value = WordW'(run_q);
        tok.nbits = TokBitsW'(RUN_WIDTH);
        tok.last  = (kind_q == K_LIMIT);
        if (emit) begin
          run_d = '0;
          idx_d = '0;
          case (kind_q)
            K_END:   state_d = S_END_TOK;
            K_SET:   state_d = S_HDR;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_HDR: begin
        tok_en    = 1'b1;
        tok.value = WordW'(widths_q[idx_q]);
        tok.nbits = TokBitsW'(HEADER_WIDTH);
        tok.align = (idx_q == LastCh);
        if (emit) begin
          if (idx_q == LastCh) begin
            pay_d   = '0;
            pch_d   = '0;
            state_d = S_PAY_RD;
          end else begin
            idx_d = idx_q + ChW'(1);
          end
        end
      end
      S_PAY_RD: begin
        rd_en_o = 1'b1;
        state_d = S_PAY_OUT;
      end
      S_PAY_OUT: begin
        tok_en    = 1'b1;
        tok.value = rd_data_i;
        tok.nbits = widths_q[pch_q];
        tok.last  = (pay_q == LastPos);
        if (emit) begin
          if (pay_q == LastPos) begin
            state_d = S_IDLE;
          end else begin
            pay_d   = pay_q + AddrW'(1);
            pch_d   = (pch_q == LastCh) ? '0 : pch_q + ChW'(1);
            state_d = S_PAY_RD;
          end
        end
      end
      S_END_TOK: begin
        tok_en    = 1'b1;
        tok.align = 1'b1;
        tok.last  = 1'b1;
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_END;
      idx_q       <= '0;
      pay_q       <= '0;
      pch_q       <= '0;
      any_q       <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      pay_q   <= pay_d;
      pch_q   <= pch_d;
      any_q   <= any_d;
      run_q   <= run_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // channel widths, one per cycle through the width unit
  always_ff @(posedge clk_i) begin
    if (state_q == S_WIDTH) begin
      widths_q[idx_q] <= width_new;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= tok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_q;

`ifndef NO_ASSERTIONS
  // a pending run never sits at the limit between items
  a_run_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (run_q != RunLimit))
    else $error("zero run reached its limit without a flush");

  // a token marked last ends the work of its item
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && tok.last) |=> (state_q == S_IDLE))
    else $error("sequencer busy after the last token");

  // a residual is computed only for a sample just taken
  a_calc_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> $past(in_acc && !in_mode_i))
    else $error("residual step without a sample transaction");

  // a store read leads straight into the payload output state
  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> (state_q == S_PAY_OUT))
    else $error("store read not followed by a payload token");
`endif

endmodule

### rtl/delta_zigzag_bitpack_rle_encoder.sv
// Sample transaction: capture, then residual through the history unit.
// Set completion: the channels step in turn through the shared width unit, then a decide step,
// then one step per header or run token, and a store read step plus an output step per payload token.
// An end transaction is accepted in the idle state, then emits its tokens; input is not ready while busy.
// Reset (async, active low) clears history, masks, run count and position;
// the residual store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// delta_zigzag_bitpack_rle_encoder
// Second-order delta, zigzag and per-channel bit-width encoder with zero-set
// run-length coding, emitting (value, width, align) tokens.
// ----------------------------------------------------------------------------
module delta_zigzag_bitpack_rle_encoder import dzbr_pkg::*; #(
  parameter int unsigned CHANNELS     = DefChannels,
  parameter int unsigned ROWS         = DefRows,
  parameter int unsigned HEADER_WIDTH = DefHeaderWidth,
  parameter int unsigned RUN_WIDTH    = DefRunWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] token_value, [20:16] token_bits, rest zero
  output logic        m_axis_tuser_o,   // [0] align_after
  output logic        m_axis_tlast_o
);

  localparam int unsigned SetSize = CHANNELS * ROWS;
  localparam int unsigned AddrW   = $clog2(SetSize);

  hist_ctrl_t                     hist;
  logic                           set_end;
  logic [CHANNELS-1:0][WordW-1:0] masks;
  logic                           wr_en;
  logic [AddrW-1:0]               wr_addr;
  logic [WordW-1:0]               wr_data;
  logic                           rd_en;
  logic [AddrW-1:0]               rd_addr;
  logic [WordW-1:0]               rd_data;
  token_t                         tok;

  // sample history and residual unit
  dzbr_history #(
    .CHANNELS (CHANNELS),
    .ROWS     (ROWS)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (hist),
    .sample_i  (s_axis_tdata_i),
    .set_end_o (set_end),
    .masks_o   (masks),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  // residuals of the current set
  dzbr_store #(
    .DEPTH (SetSize)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sequencer and token output
  dzbr_ctrl #(
    .CHANNELS     (CHANNELS),
    .ROWS         (ROWS),
    .HEADER_WIDTH (HEADER_WIDTH),
    .RUN_WIDTH    (RUN_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .hist_o      (hist),
    .set_end_i   (set_end),
    .masks_i     (masks),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tok_o   (tok)
  );

  // output packing
  assign m_axis_tdata_o = {3'b000, tok.nbits, tok.value};
  assign m_axis_tuser_o = tok.align;
  assign m_axis_tlast_o = tok.last;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the delta/zigzag/bit-width/run-length encoder: a
// scoreboard keeps its own copy of the sample history and set state, predicts
// every token for each accepted input transaction and compares the output
// stream token by token, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import dzbr_pkg::*;

  localparam int unsigned NumCh      = DefChannels;
  localparam int unsigned NumRows    = DefRows;
  localparam int unsigned HdrW       = DefHeaderWidth;
  localparam int unsigned RunW       = DefRunWidth;
  localparam int unsigned SetSize    = NumCh * NumRows;
  localparam int unsigned RunLimit   = (1 << RunW) - 1;
  localparam int unsigned RxHoldLen  = 300;
  localparam int unsigned TailCycles = 64;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_END    = 1'b1
  } item_mode_e;

  // expected token stream of the encoder
  class token_scoreboard;
    logic [15:0] older_hist[NumCh];
    logic [15:0] newer_hist[NumCh];
    logic [15:0] zz_residuals[SetSize];
    logic [15:0] width_mask[NumCh];
    int unsigned zero_sets;
    int unsigned set_pos;
    token_t      expected_tokens[$];
    int unsigned mismatches;

    function new();
      for (int c = 0; c < NumCh; c++) begin
        older_hist[c] = '0;
        newer_hist[c] = '0;
        width_mask[c] = '0;
      end
      zero_sets   = 0;
      set_pos     = 0;
      mismatches  = 0;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    // sample that gives a zero residual at the current position
    function logic [15:0] zero_residual_sample();
      int unsigned ch;
      ch = set_pos % NumCh;
      return (newer_hist[ch] << 1) - older_hist[ch];
    endfunction

    function void push_token(logic [15:0] value, int unsigned nbits, logic align);
      token_t tok;
      tok.value = value;
      tok.nbits = nbits[TokBitsW-1:0];
      tok.align = align;
      tok.last  = 1'b0;
      expected_tokens.push_back(tok);
    endfunction

    function int unsigned width_of(logic [15:0] v);
      int unsigned w;
      w = 0;
      for (int b = 0; b < 16; b++)
        if (v[b]) w = b + 1;
      return w;
    endfunction

    // pending zero sets: zero headers, align, then the run count
    function void flush_zero_run();
      if (zero_sets == 0) return;
      for (int c = 0; c < NumCh; c++)
        push_token('0, HdrW, c == NumCh - 1);
      push_token(16'(zero_sets & RunLimit), RunW, 1'b0);
      zero_sets = 0;
    endfunction

    // end of a set: count a zero set or emit headers and payload
    function void close_set();
      int unsigned widths[NumCh];
      bit          all_zero;
      all_zero = 1'b1;
      for (int c = 0; c < NumCh; c++) begin
        widths[c] = width_of(width_mask[c]);
        if (widths[c] != 0) all_zero = 1'b0;
      end
      if (all_zero) begin
        zero_sets++;
        if (zero_sets >= RunLimit) flush_zero_run();
      end else begin
        flush_zero_run();
        for (int c = 0; c < NumCh; c++)
          push_token(16'(widths[c]), HdrW, c == NumCh - 1);
        for (int p = 0; p < SetSize; p++)
          push_token(zz_residuals[p], widths[p % NumCh], 1'b0);
      end
      for (int c = 0; c < NumCh; c++) width_mask[c] = '0;
      set_pos = 0;
    endfunction

    // accepted input transaction
    function void note_input(item_mode_e mode, logic [15:0] sample);
      int unsigned queued;
      int unsigned ch;
      logic [15:0] pred;
      logic [15:0] resid;
      logic [15:0] zz;
      token_t      tail;
      queued = expected_tokens.size();
      if (mode == MODE_END) begin
        for (int c = 0; c < NumCh; c++) width_mask[c] = '0;
        set_pos = 0;
        flush_zero_run();
        push_token('0, 0, 1'b1);
      end else begin
        ch    = set_pos % NumCh;
        pred  = (newer_hist[ch] << 1) - older_hist[ch];
        resid = pred - sample;
        zz    = {resid[14:0], 1'b0} ^ {16{resid[15]}};
        older_hist[ch]        = newer_hist[ch];
        newer_hist[ch]        = sample;
        zz_residuals[set_pos] = zz;
        width_mask[ch]        = width_mask[ch] | zz;
        set_pos++;
        if (set_pos >= SetSize) close_set();
      end
      // final token of this transaction carries the last flag
      if (expected_tokens.size() > queued) begin
        tail      = expected_tokens.pop_back();
        tail.last = 1'b1;
        expected_tokens.push_back(tail);
      end
    endfunction

    // accepted output transaction against the oldest expectation
    function void check_token(token_t got);
      token_t exp_tok;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: value %h bits %0d align %b last %b",
               got.value, got.nbits, got.align, got.last);
        mismatches++;
        return;
      end
      exp_tok = expected_tokens.pop_front();
      if (got.value !== exp_tok.value) begin
        $error("token_value: expected %h, actual %h", exp_tok.value, got.value);
        mismatches++;
      end
      if (got.nbits !== exp_tok.nbits) begin
        $error("token_bits: expected %0d, actual %0d", exp_tok.nbits, got.nbits);
        mismatches++;
      end
      if (got.align !== exp_tok.align) begin
        $error("align_after: expected %b, actual %b", exp_tok.align, got.align);
        mismatches++;
      end
      if (got.last !== exp_tok.last) begin
        $error("last: expected %b, actual %b", exp_tok.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  token_scoreboard sb = new();
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  bit              rx_hold_req;
  int unsigned     items_sent;

  delta_zigzag_bitpack_rle_encoder #(
    .CHANNELS    (NumCh),
    .ROWS        (NumRows),
    .HEADER_WIDTH(HdrW),
    .RUN_WIDTH   (RunW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: random back-pressure, long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RxHoldLen - 1) @(posedge clk_i);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    token_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.value = m_tdata[15:0];
      got.nbits = m_tdata[20:16];
      got.align = m_tuser;
      got.last  = m_tlast;
      sb.check_token(got);
    end
  end

  // one input transaction, with random idle cycles in front
  task automatic drive_item(item_mode_e mode, logic [15:0] sample);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= mode;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_input(mode, sample);
    items_sent++;
  endtask

  // sender pause until every expected token has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // full set with a chosen residual width per channel (zero_set: all zero)
  task automatic send_set(bit zero_set);
    int unsigned width_sel[NumCh];
    bit          full_range;
    logic [15:0] resid;
    int unsigned ch;
    full_range = ($urandom_range(7) == 0);
    for (int c = 0; c < NumCh; c++) begin
      if (zero_set) width_sel[c] = 0;
      else if (full_range) width_sel[c] = 16;
      else if ($urandom_range(3) == 0) width_sel[c] = 0;
      else width_sel[c] = $urandom_range(1, 16);
    end
    for (int p = 0; p < SetSize; p++) begin
      ch = p % NumCh;
      if (width_sel[ch] == 0) resid = '0;
      else if (width_sel[ch] == 16) resid = 16'($urandom);
      else resid = 16'($urandom_range(0, (1 << width_sel[ch]) - 1)
                       - (1 << (width_sel[ch] - 1)));
      drive_item(MODE_SAMPLE, sb.zero_residual_sample() - resid);
    end
  endtask

  // unfinished set cut short by an end transaction
  task automatic send_cut_set();
    int unsigned n;
    n = $urandom_range(1, SetSize - 1);
    repeat (n) drive_item(MODE_SAMPLE, 16'($urandom));
    drive_item(MODE_END, 16'($urandom));
  endtask

  // random sequences until the given number of items went in
  task automatic random_sequences(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(6))
        0: drive_item(MODE_END, 16'($urandom));
        1: send_cut_set();
        2: send_set(1'b1);
        default: send_set(1'b0);
      endcase
    end
  endtask

  // main stimulus
  initial begin
    rst_ni      <= 1'b0;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= MODE_SAMPLE;
    tx_idle_pct  = 13;
    rx_idle_pct  = 82;
    rx_hold_req  = 1'b0;
    items_sent   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // end with nothing pending, then field extremes in an unfinished set
    drive_item(MODE_END, 16'h0000);
    drive_item(MODE_SAMPLE, 16'h0000);
    drive_item(MODE_SAMPLE, 16'hFFFF);
    drive_item(MODE_SAMPLE, 16'h8000);
    drive_item(MODE_SAMPLE, 16'h7FFF);
    drive_item(MODE_SAMPLE, 16'h0001);
    drive_item(MODE_SAMPLE, 16'hFFFE);
    drive_item(MODE_SAMPLE, 16'h5555);
    drive_item(MODE_SAMPLE, 16'hAAAA);
    drive_item(MODE_SAMPLE, 16'h8001);
    drive_item(MODE_END, 16'hFFFF);
    drive_item(MODE_END, 16'h5A5A);

    // unfinished set, then a zero set left pending as a run
    send_cut_set();
    send_set(1'b1);
    wait_drained();

    // swapped idling, long receiver hold-off while a nonzero set flushes the run
    tx_idle_pct = 82;
    rx_idle_pct = 13;
    rx_hold_req = 1'b1;
    tx_idle_pct = 0;
    send_set(1'b0);
    tx_idle_pct = 82;
    drive_item(MODE_END, 16'($urandom));
    send_cut_set();
    wait_drained();

    // no idling on either side, zero run flushed by an end transaction
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_set(1'b1);
    drive_item(MODE_END, 16'($urandom));
    random_sequences(4);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
